### rtl/core/vrp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrp_pkg
// shared types, register indexes and fixed-point helpers for the vertex
// rotate and project block
// ----------------------------------------------------------------------------
package vrp_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int QB         = 17;
    localparam int NW         = 49;
    localparam int DW         = 33;
    localparam int PRW        = 48;

    typedef enum logic [2:0] {
        CFG_COS    = 3'd0,
        CFG_SIN    = 3'd1,
        CFG_FOV    = 3'd2,
        CFG_WIDTH  = 3'd3,
        CFG_HEIGHT = 3'd4,
        CFG_MODE   = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic signed [15:0] cos_v;
        logic signed [15:0] sin_v;
        logic               mode;
    } rot_cfg_t;

    typedef struct packed {
        logic signed [31:0] fov;
        logic signed [12:0] off_x;
        logic signed [12:0] off_y;
    } proj_cfg_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } point_t;

    // floor shift by 14 then clamp to 32-bit signed
    function automatic logic signed [31:0] fix_sat(input logic signed [48:0] v);
        logic signed [34:0] t;
        begin
            t = v[48:14];
            if (t > 35'sd2147483647)
                fix_sat = 32'sh7FFFFFFF;
            else if (t < -35'sd2147483648)
                fix_sat = 32'sh80000000;
            else
                fix_sat = t[31:0];
        end
    endfunction

endpackage

### rtl/core/vertex_rotate_project.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_rotate_project
// rotates a Q16.16 point by one angle and projects it to a 16-bit screen
// point
//
// input channel: in_valid / in_stall with point_x, point_y, point_z
// output channel: out_valid / out_stall with screen_x, screen_y, div_error
// config: wr_en, wr_index, wr_data; write only while the block is idle
// throughput: one beat per cycle in both directions while neither channel stalls
// path: rotation, then the queue, then the projection arithmetic, then the
//   restoring divide (a load stage, then one quotient bit per stage), then
//   the output register
// reset: config returns to its reset values, queue and pipelines empty
// out_stall holds the back pipeline and the output register once that
//   register holds a beat; the rotation front keeps accepting beats until
//   the 4-entry queue is full and a rotated point waits, then raises in_stall
// window offsets are recomputed in the cycle after a width or height write
// ----------------------------------------------------------------------------
module vertex_rotate_project
    import vrp_pkg::*;
#(
    parameter int PROJ_SCALE = 400
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [2:0]         wr_index,
    input  logic [31:0]        wr_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] screen_x,
    output logic signed [15:0] screen_y,
    output logic               div_error
);

    logic signed [15:0] cos_reg, sin_reg;
    logic signed [31:0] fov_reg;
    logic [13:0]        width_reg, height_reg;
    logic               mode_reg;
    logic [10:0]        offx_reg;
    logic [11:0]        offy_reg;
    logic [29:0]        wx_prod, hy_prod;

    rot_cfg_t  rcfg;
    proj_cfg_t pcfg;
    point_t    pt_in, f_pt, q_pt;
    logic      f_en, f_vld, q_full, q_empty, q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_reg    <= 16'sd16384;
            sin_reg    <= 16'sd0;
            fov_reg    <= 32'sd0;
            width_reg  <= 14'd640;
            height_reg <= 14'd480;
            mode_reg   <= 1'b0;
            offx_reg   <= 11'd64;
            offy_reg   <= 12'd96;
        end
        else
        begin
            if (wr_en)
            begin
                case (cfg_idx_t'(wr_index))
                    CFG_COS:    cos_reg    <= wr_data[15:0];
                    CFG_SIN:    sin_reg    <= wr_data[15:0];
                    CFG_FOV:    fov_reg    <= wr_data;
                    CFG_WIDTH:  width_reg  <= wr_data[13:0];
                    CFG_HEIGHT: height_reg <= wr_data[13:0];
                    CFG_MODE:   mode_reg   <= wr_data[0];
                    default:    ;
                endcase
            end
            offx_reg <= wx_prod[29:19];
            offy_reg <= hy_prod[29:18];
        end
    end

    // floor(w/10) and floor(h/5) by reciprocal
    assign wx_prod = 30'(width_reg) * 30'd52429;
    assign hy_prod = 30'(height_reg) * 30'd52429;

    assign rcfg.cos_v = cos_reg;
    assign rcfg.sin_v = sin_reg;
    assign rcfg.mode  = mode_reg;
    assign pcfg.fov   = fov_reg;
    assign pcfg.off_x = 13'($signed({2'b00, offx_reg}));
    assign pcfg.off_y = -13'($signed({1'b0, offy_reg}));

    assign pt_in.x = point_x;
    assign pt_in.y = point_y;
    assign pt_in.z = point_z;

    assign f_en     = !(f_vld && q_full);
    assign in_stall = !f_en;

    vrp_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (f_en),
        .rcfg   (rcfg),
        .in_vld (in_valid),
        .pt_in  (pt_in),
        .out_vld(f_vld),
        .pt_out (f_pt)
    );

    vrp_fifo u_fifo (
        .clk  (clk),
        .rst_n(rst_n),
        .push (f_vld && !q_full),
        .wdata(f_pt),
        .pop  (q_pop),
        .rdata(q_pt),
        .full (q_full),
        .empty(q_empty)
    );

    vrp_back #(
        .PROJ_SCALE(PROJ_SCALE)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .pcfg     (pcfg),
        .q_empty  (q_empty),
        .q_data   (q_pt),
        .q_pop    (q_pop),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .screen_x (screen_x),
        .screen_y (screen_y),
        .div_error(div_error)
    );

endmodule

### rtl/core/vrp_rot.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrp_rot
// one plane rotation: na = c*a - s*b, nb = c*b + s*a, multiply then sum
// ----------------------------------------------------------------------------
module vrp_rot
    import vrp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  rot_cfg_t           rcfg,
    input  logic               bypass,
    input  logic               in_vld,
    input  logic signed [31:0] a_in,
    input  logic signed [31:0] b_in,
    input  logic signed [31:0] c_in,
    output logic               out_vld,
    output logic signed [31:0] a_out,
    output logic signed [31:0] b_out,
    output logic signed [31:0] c_out
);

    logic                   v1_reg;
    logic                   byp1_reg;
    logic signed [PRW-1:0]  ca_reg, sb_reg, cb_reg, sa_reg;
    logic signed [31:0]     a1_reg, b1_reg, c1_reg;
    logic                   v2_reg;
    logic signed [31:0]     a2_reg, b2_reg, c2_reg;
    logic signed [31:0]     a2_next, b2_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_vld;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ca_reg   <= PRW'(rcfg.cos_v) * PRW'(a_in);
            sb_reg   <= PRW'(rcfg.sin_v) * PRW'(b_in);
            cb_reg   <= PRW'(rcfg.cos_v) * PRW'(b_in);
            sa_reg   <= PRW'(rcfg.sin_v) * PRW'(a_in);
            a1_reg   <= a_in;
            b1_reg   <= b_in;
            c1_reg   <= c_in;
            byp1_reg <= bypass;
            a2_reg   <= a2_next;
            b2_reg   <= b2_next;
            c2_reg   <= c1_reg;
        end
    end

    always_comb
    begin
        if (byp1_reg)
        begin
            a2_next = a1_reg;
            b2_next = b1_reg;
        end
        else
        begin
            a2_next = fix_sat(49'(ca_reg) - 49'(sb_reg));
            b2_next = fix_sat(49'(cb_reg) + 49'(sa_reg));
        end
    end

    assign out_vld = v2_reg;
    assign a_out   = a2_reg;
    assign b_out   = b2_reg;
    assign c_out   = c2_reg;

endmodule

### rtl/core/vrp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrp_front
// rotation front end: optional z rotation, then y, then x
// ----------------------------------------------------------------------------
module vrp_front
    import vrp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  rot_cfg_t rcfg,
    input  logic     in_vld,
    input  point_t   pt_in,
    output logic     out_vld,
    output point_t   pt_out
);

    logic               vz, vy;
    logic signed [31:0] zx, zy, zz;
    logic signed [31:0] yz, yx, yy;
    logic signed [31:0] xy, xz, xx;

    // z: a=x b=y
    vrp_rot u_rot_z (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .rcfg   (rcfg),
        .bypass (!rcfg.mode),
        .in_vld (in_vld),
        .a_in   (pt_in.x),
        .b_in   (pt_in.y),
        .c_in   (pt_in.z),
        .out_vld(vz),
        .a_out  (zx),
        .b_out  (zy),
        .c_out  (zz)
    );

    // y: a=z b=x
    vrp_rot u_rot_y (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .rcfg   (rcfg),
        .bypass (1'b0),
        .in_vld (vz),
        .a_in   (zz),
        .b_in   (zx),
        .c_in   (zy),
        .out_vld(vy),
        .a_out  (yz),
        .b_out  (yx),
        .c_out  (yy)
    );

    // x: a=y b=z
    vrp_rot u_rot_x (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .rcfg   (rcfg),
        .bypass (1'b0),
        .in_vld (vy),
        .a_in   (yy),
        .b_in   (yz),
        .c_in   (yx),
        .out_vld(out_vld),
        .a_out  (xy),
        .b_out  (xz),
        .c_out  (xx)
    );

    assign pt_out.x = xx;
    assign pt_out.y = xy;
    assign pt_out.z = xz;

endmodule

### rtl/core/vrp_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrp_fifo
// short queue of rotated points between front and back
// ----------------------------------------------------------------------------
module vrp_fifo
    import vrp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  point_t wdata,
    input  logic   pop,
    output point_t rdata,
    output logic   full,
    output logic   empty
);

    point_t             mem_reg [0:FIFO_DEPTH-1];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]   cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

    assign rdata = mem_reg[rd_ptr_reg];
    assign full  = (cnt_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign empty = (cnt_reg == '0);

endmodule

### rtl/core/vrp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrp_back
// projection back end: numerators, pipelined restoring divide, saturation
// ----------------------------------------------------------------------------
module vrp_back
    import vrp_pkg::*;
#(
    parameter int PROJ_SCALE = 400
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  proj_cfg_t          pcfg,
    input  logic               q_empty,
    input  point_t             q_data,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] screen_x,
    output logic signed [15:0] screen_y,
    output logic               div_error
);

    logic en;

    // stage 0: fov sums
    logic                   v0_reg;
    logic signed [DW-1:0]   den0_reg, nx0_reg, ny0_reg;
    // stage 1: products
    logic                   v1_reg;
    logic signed [PRW-1:0]  px1_reg, px2_reg, py1_reg, py2_reg;
    logic signed [DW-1:0]   den1_reg;
    // stage 2: magnitudes
    logic                   v2_reg;
    logic [NW-1:0]          mx2_reg, my2_reg;
    logic                   negx2_reg, negy2_reg, zero2_reg;
    logic [DW-1:0]          d2_reg;
    logic signed [NW-1:0]   nsx, nsy;
    // divide stages
    logic                   vd_reg   [0:QB];
    logic [DW-1:0]          rx_reg   [0:QB];
    logic [DW-1:0]          ry_reg   [0:QB];
    logic [QB-1:0]          qx_reg   [0:QB];
    logic [QB-1:0]          qy_reg   [0:QB];
    logic [QB-1:0]          lx_reg   [0:QB];
    logic [QB-1:0]          ly_reg   [0:QB];
    logic [DW-1:0]          dd_reg   [0:QB];
    logic                   ovx_reg  [0:QB];
    logic                   ovy_reg  [0:QB];
    logic                   ngx_reg  [0:QB];
    logic                   ngy_reg  [0:QB];
    logic                   zr_reg   [0:QB];
    // output
    logic                   ov_reg;
    logic signed [15:0]     sx_reg, sy_reg;
    logic                   err_reg;
    logic signed [15:0]     sx_next, sy_next;

    assign en    = !ov_reg || !out_stall;
    assign q_pop = en && !q_empty;

    assign nsx = NW'(px1_reg) + NW'(px2_reg);
    assign nsy = NW'(py1_reg) + NW'(py2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg    <= 1'b0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            vd_reg[0] <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else if (en)
        begin
            v0_reg    <= q_pop;
            v1_reg    <= v0_reg;
            v2_reg    <= v1_reg;
            vd_reg[0] <= v2_reg;
            ov_reg    <= vd_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den0_reg  <= DW'(pcfg.fov) + DW'(q_data.z);
            nx0_reg   <= DW'(pcfg.fov) + DW'(q_data.x);
            ny0_reg   <= DW'(pcfg.fov) + DW'(q_data.y);

            px1_reg   <= PRW'(pcfg.off_x) * PRW'(den0_reg);
            px2_reg   <= PRW'(nx0_reg) * PRW'(PROJ_SCALE);
            py1_reg   <= PRW'(pcfg.off_y) * PRW'(den0_reg);
            py2_reg   <= PRW'(ny0_reg) * PRW'(PROJ_SCALE);
            den1_reg  <= den0_reg;

            mx2_reg   <= nsx[NW-1] ? NW'(-nsx) : NW'(nsx);
            my2_reg   <= nsy[NW-1] ? NW'(-nsy) : NW'(nsy);
            negx2_reg <= nsx[NW-1] ^ den1_reg[DW-1];
            negy2_reg <= nsy[NW-1] ^ den1_reg[DW-1];
            zero2_reg <= (den1_reg == '0);
            d2_reg    <= den1_reg[DW-1] ? DW'(-den1_reg) : DW'(den1_reg);

            ovx_reg[0] <= ({1'b0, mx2_reg[NW-1:QB]} >= d2_reg);
            ovy_reg[0] <= ({1'b0, my2_reg[NW-1:QB]} >= d2_reg);
            rx_reg[0]  <= {1'b0, mx2_reg[NW-1:QB]};
            ry_reg[0]  <= {1'b0, my2_reg[NW-1:QB]};
            lx_reg[0]  <= mx2_reg[QB-1:0];
            ly_reg[0]  <= my2_reg[QB-1:0];
            qx_reg[0]  <= '0;
            qy_reg[0]  <= '0;
            dd_reg[0]  <= d2_reg;
            ngx_reg[0] <= negx2_reg;
            ngy_reg[0] <= negy2_reg;
            zr_reg[0]  <= zero2_reg;

            sx_reg  <= sx_next;
            sy_reg  <= sy_next;
            err_reg <= zr_reg[QB];
        end
    end

    genvar k;
    generate
        for (k = 1; k <= QB; k++)
        begin : g_div
            logic [DW:0] tx, ty;
            logic        bx, by;

            assign tx = {rx_reg[k-1], lx_reg[k-1][QB-1]};
            assign ty = {ry_reg[k-1], ly_reg[k-1][QB-1]};
            assign bx = (tx >= {1'b0, dd_reg[k-1]});
            assign by = (ty >= {1'b0, dd_reg[k-1]});

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vd_reg[k] <= 1'b0;
                else if (en)
                    vd_reg[k] <= vd_reg[k-1];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rx_reg[k]  <= bx ? DW'(tx - {1'b0, dd_reg[k-1]}) : DW'(tx);
                    ry_reg[k]  <= by ? DW'(ty - {1'b0, dd_reg[k-1]}) : DW'(ty);
                    qx_reg[k]  <= {qx_reg[k-1][QB-2:0], bx};
                    qy_reg[k]  <= {qy_reg[k-1][QB-2:0], by};
                    lx_reg[k]  <= {lx_reg[k-1][QB-2:0], 1'b0};
                    ly_reg[k]  <= {ly_reg[k-1][QB-2:0], 1'b0};
                    dd_reg[k]  <= dd_reg[k-1];
                    ovx_reg[k] <= ovx_reg[k-1];
                    ovy_reg[k] <= ovy_reg[k-1];
                    ngx_reg[k] <= ngx_reg[k-1];
                    ngy_reg[k] <= ngy_reg[k-1];
                    zr_reg[k]  <= zr_reg[k-1];
                end
            end
        end
    endgenerate

    // sign and clamp
    always_comb
    begin
        if (zr_reg[QB])
            sx_next = '0;
        else if (ngx_reg[QB])
            sx_next = (ovx_reg[QB] || qx_reg[QB] > QB'(32768)) ? 16'sh8000
                                                               : 16'(-qx_reg[QB]);
        else
            sx_next = (ovx_reg[QB] || qx_reg[QB] > QB'(32767)) ? 16'sh7FFF
                                                               : 16'(qx_reg[QB]);

        if (zr_reg[QB])
            sy_next = '0;
        else if (ngy_reg[QB])
            sy_next = (ovy_reg[QB] || qy_reg[QB] > QB'(32768)) ? 16'sh8000
                                                               : 16'(-qy_reg[QB]);
        else
            sy_next = (ovy_reg[QB] || qy_reg[QB] > QB'(32767)) ? 16'sh7FFF
                                                               : 16'(qy_reg[QB]);
    end

    assign out_valid = ov_reg;
    assign screen_x  = sx_reg;
    assign screen_y  = sy_reg;
    assign div_error = err_reg;

endmodule

### tb/tb_vertex_rotate_project.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vertex_rotate_project
// streams Q16.16 points through the rotate and project block over several
// register settings, predicts every screen point in the bench and checks
// each output beat in order, with random idling on both channels and one
// long hold-off on the output side
// ----------------------------------------------------------------------------
module tb_vertex_rotate_project
    import vrp_pkg::*;
();

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } vertex_t;

    typedef struct {
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic               err;
    } screen_pt_t;

    logic               clk;
    logic               rst_n;
    logic               wr_en;
    logic [2:0]         wr_index;
    logic [31:0]        wr_data;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               out_valid;
    logic               out_stall;
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
    logic               div_error;

    vertex_t    pending_pts[$];
    screen_pt_t expected_pts[$];

    logic signed [63:0] m_cos;
    logic signed [63:0] m_sin;
    logic signed [63:0] m_fov;
    logic signed [63:0] m_width;
    logic signed [63:0] m_height;
    logic               m_mode;

    int  mismatches;
    int  in_gap;
    int  out_gap;
    int  hold_cycles;
    bit  quiet;
    bit  hold_req;

    vertex_rotate_project i_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic signed [63:0] floor_sat(input logic signed [63:0] v);
        logic signed [63:0] r;
        begin
            r = v >>> 14;
            if (r > 64'sd2147483647)
                r = 64'sd2147483647;
            else if (r < -64'sd2147483648)
                r = -64'sd2147483648;
            return r;
        end
    endfunction

    function automatic logic signed [15:0] screen_coord(input logic signed [63:0] offset,
        input logic signed [63:0] num, input logic signed [63:0] den);
        logic signed [63:0] t;
        begin
            t = (offset * den + num * 64'sd400) / den;
            if (t > 64'sd32767)
                t = 64'sd32767;
            else if (t < -64'sd32768)
                t = -64'sd32768;
            return t[15:0];
        end
    endfunction

    function automatic screen_pt_t project_vertex(input vertex_t p);
        logic signed [63:0] x, y, z, nx, ny, nz, den;
        screen_pt_t r;
        begin
            x = p.x;
            y = p.y;
            z = p.z;
            if (m_mode)
            begin
                nx = floor_sat(m_cos * x - m_sin * y);
                ny = floor_sat(m_cos * y + m_sin * x);
                x = nx;
                y = ny;
            end
            nx = floor_sat(m_cos * x + m_sin * z);
            nz = floor_sat(m_cos * z - m_sin * x);
            x = nx;
            z = nz;
            ny = floor_sat(m_cos * y - m_sin * z);
            nz = floor_sat(m_sin * y + m_cos * z);
            y = ny;
            z = nz;
            den = m_fov + z;
            if (den == 0)
            begin
                r.sx = '0;
                r.sy = '0;
                r.err = 1'b1;
            end
            else
            begin
                r.sx = screen_coord(m_width / 10, m_fov + x, den);
                r.sy = screen_coord(-(m_height / 5), m_fov + y, den);
                r.err = 1'b0;
            end
            return r;
        end
    endfunction

    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
        begin
            @(posedge clk);
            wr_en <= 1'b1;
            wr_index <= idx;
            wr_data <= val;
            @(posedge clk);
            wr_en <= 1'b0;
            case (idx)
                CFG_COS:    m_cos = $signed(val[15:0]);
                CFG_SIN:    m_sin = $signed(val[15:0]);
                CFG_FOV:    m_fov = $signed(val);
                CFG_WIDTH:  m_width = val[13:0];
                CFG_HEIGHT: m_height = val[13:0];
                CFG_MODE:   m_mode = val[0];
                default: ;
            endcase
            @(posedge clk);
        end
    endtask

    task automatic set_rotation(input logic signed [15:0] c, input logic signed [15:0] s,
        input logic signed [31:0] fov, input logic [13:0] w, input logic [13:0] h,
        input logic mode);
        begin
            write_reg(CFG_COS, {16'h0, c});
            write_reg(CFG_SIN, {16'h0, s});
            write_reg(CFG_FOV, fov);
            write_reg(CFG_WIDTH, {18'h0, w});
            write_reg(CFG_HEIGHT, {18'h0, h});
            write_reg(CFG_MODE, {31'h0, mode});
            repeat (3) @(posedge clk);
        end
    endtask

    task automatic queue_vertex(input logic signed [31:0] x, input logic signed [31:0] y,
        input logic signed [31:0] z);
        vertex_t p;
        begin
            p.x = x;
            p.y = y;
            p.z = z;
            pending_pts.push_back(p);
            expected_pts.push_back(project_vertex(p));
        end
    endtask

    function automatic logic signed [31:0] rand_coord();
        int k;
        begin
            k = $urandom_range(0, 9);
            if (k < 2)
                return $urandom;
            else if (k < 4)
                return $signed($urandom_range(0, 32'h0001FFFF)) - 32'sh00010000;
            else
                return $signed($urandom_range(0, 32'h03FFFFFF)) - 32'sh02000000;
        end
    endfunction

    task automatic wait_drain();
        begin
            while (pending_pts.size() != 0 || expected_pts.size() != 0)
                @(posedge clk);
            repeat (40) @(posedge clk);
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gap <= 0;
            point_x <= '0;
            point_y <= '0;
            point_z <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
                void'(pending_pts.pop_front());
            if (in_valid && in_stall)
                ;
            else if (in_gap > 0)
            begin
                in_gap <= in_gap - 1;
                in_valid <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                in_gap <= $urandom_range(1, 9) - 1;
                in_valid <= 1'b0;
            end
            else if (pending_pts.size() > 0)
            begin
                vertex_t p;
                p = pending_pts[0];
                in_valid <= 1'b1;
                point_x <= p.x;
                point_y <= p.y;
                point_z <= p.z;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_gap <= 0;
            hold_cycles <= 0;
        end
        else
        begin
            if (hold_req && hold_cycles == 0)
            begin
                hold_cycles <= 300;
                out_stall <= 1'b1;
            end
            else if (hold_cycles > 1)
                hold_cycles <= hold_cycles - 1;
            else if (hold_cycles == 1)
            begin
                hold_cycles <= -1;
                out_stall <= 1'b0;
            end
            else if (out_gap > 0)
                out_gap <= out_gap - 1;
            else if (out_stall)
                out_stall <= 1'b0;
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                out_gap <= $urandom_range(1, 9) - 1;
                out_stall <= 1'b1;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mismatches <= 0;
        else if (out_valid && !out_stall)
        begin
            if (expected_pts.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected beat: sx=%0d sy=%0d err=%0b",
                        screen_x, screen_y, div_error);
                mismatches <= mismatches + 1;
            end
            else
            begin
                screen_pt_t e;
                e = expected_pts.pop_front();
                if (e.sx !== screen_x || e.sy !== screen_y || e.err !== div_error)
                begin
                    if (mismatches < 10)
                        $display("mismatch: exp sx=%0d sy=%0d err=%0b got sx=%0d sy=%0d err=%0b",
                            e.sx, e.sy, e.err, screen_x, screen_y, div_error);
                    mismatches <= mismatches + 1;
                end
            end
        end
    end

    initial
    begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        logic signed [31:0] ext[4];
        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_index = '0;
        wr_data = '0;
        quiet = 1'b0;
        hold_req = 1'b0;
        m_cos = 16384;
        m_sin = 0;
        m_fov = 0;
        m_width = 640;
        m_height = 480;
        m_mode = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset settings: zero divisor, extremes
        ext = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh00010000, -32'sh00010000};
        queue_vertex(0, 0, 0);
        queue_vertex(32'sh00010000, 32'sh00010000, 0);
        foreach (ext[i])
            queue_vertex(ext[i], ext[(i + 1) % 4], ext[(i + 2) % 4]);
        queue_vertex(32'sh7FFFFFFF, 32'sh7FFFFFFF, 1);
        queue_vertex(32'sh80000000, 32'sh80000000, -1);
        wait_drain();

        set_rotation(16'sh8000, 16'sh7FFF, 32'sh7FFFFFFF, 14'h3FFF, 14'h3FFF, 1'b1);
        foreach (ext[i])
            queue_vertex(ext[i], ext[(i + 3) % 4], ext[(i + 1) % 4]);
        queue_vertex(0, 0, -32'sh7FFFFFFF);
        wait_drain();

        set_rotation(-16'sd16384, 16'sd16384, 32'sh80000000, 14'd0, 14'd0, 1'b0);
        foreach (ext[i])
            queue_vertex(ext[i], ext[(i + 2) % 4], ext[(i + 3) % 4]);
        queue_vertex(0, 0, 32'sh7FFFFFFF);
        wait_drain();

        // random phases
        for (int ph = 0; ph < 6; ph++)
        begin
            set_rotation(16'($urandom), 16'($urandom), (ph % 2) ? $urandom :
                $signed($urandom_range(0, 32'h01FFFFFF)), 14'($urandom), 14'($urandom),
                1'($urandom));
            if (ph == 5)
                quiet = 1'b1;
            if (ph == 2)
                hold_req = 1'b1;
            for (int n = 0; n < 180; n++)
            begin
                if ($urandom_range(0, 19) == 0)
                    queue_vertex(rand_coord(), rand_coord(), -m_fov[31:0]);
                else
                    queue_vertex(rand_coord(), rand_coord(), rand_coord());
            end
            wait_drain();
            hold_req = 1'b0;
        end

        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

### files.f
rtl/core/vrp_pkg.sv
rtl/core/vrp_rot.sv
rtl/core/vrp_front.sv
rtl/core/vrp_fifo.sv
rtl/core/vrp_back.sv
rtl/core/vertex_rotate_project.sv
tb/tb_vertex_rotate_project.sv
